// File: hdl/plist_pkg.sv
// Shared constants and types for the positional list engine.
// Depends on nothing; positional_list_engine_core imports it.
package plist_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 8;
    localparam int VALUE_W = 32;
    localparam int FOUND_W = 5;
    localparam int LEN_W   = 5;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_FIND   = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_MV,
        S_INS_PUT,
        S_REM_MV,
        S_FIND,
        S_READ
    } state_t;

endpackage

// File: hdl/plist_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module plist_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/positional_list_engine_core.sv
// Positional list engine: command sequencer around one entry RAM.
// Depends on plist_pkg and plist_ram.
// Insert at p into n entries moves entries n-1..p up one, then writes p; at p = n it writes at once.
// Remove moves entries above p down one (none for the last); find scans from entry 0 for a match.
// One entry moves or is compared per cycle; busy holds the next command off until the done cycle.
// Results cannot be stalled. Reset clears the length and idles the sequencer; the RAM is not cleared.
module positional_list_engine_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [plist_pkg::FUNC_W-1:0]   func,
    input  logic [plist_pkg::POS_W-1:0]    position,
    input  logic [plist_pkg::VALUE_W-1:0]  value,
    output logic                           done,
    output logic                           ok,
    output logic signed [plist_pkg::FOUND_W-1:0] found_position,
    output logic [plist_pkg::VALUE_W-1:0]  read_value,
    output logic [plist_pkg::LEN_W-1:0]    length
);

    import plist_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;

    logic                done_reg, done_next;
    logic                ok_reg, ok_next;
    logic [FOUND_W-1:0]  found_reg, found_next;
    logic [VALUE_W-1:0]  rdv_reg, rdv_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [CMP_W-1:0]      pos_ext, cnt_ext;
    logic [ADDR_W-1:0]     pos_a;
    logic [DATA_WIDTH-1:0] val_in;
    logic [CNT_W-1:0]      cnt_last;

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_a    = ADDR_W'(position);
    assign val_in   = DATA_WIDTH'(value);
    assign cnt_last = count_reg - CNT_W'(1);

    plist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        done_next  = 1'b0;
        ok_next    = 1'b0;
        found_next = '1;
        rdv_next   = '0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(func))
                        OP_INSERT:
                        begin
                            if (count_reg < CNT_W'(CAPACITY) && pos_ext <= cnt_ext)
                            begin
                                if (pos_ext == cnt_ext)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = pos_a;
                                    ram_wdata  = val_in;
                                    count_next = count_reg + CNT_W'(1);
                                    done_next  = 1'b1;
                                    ok_next    = 1'b1;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = ADDR_W'(cnt_last);
                                    ptr_next   = ADDR_W'(cnt_last);
                                    pos_next   = pos_a;
                                    val_next   = val_in;
                                    state_next = S_INS_MV;
                                end
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                if (pos_ext == CMP_W'(cnt_last))
                                begin
                                    count_next = cnt_last;
                                    done_next  = 1'b1;
                                    ok_next    = 1'b1;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = pos_a + ADDR_W'(1);
                                    ptr_next   = pos_a + ADDR_W'(1);
                                    state_next = S_REM_MV;
                                end
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                val_next   = val_in;
                                state_next = S_FIND;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = pos_a;
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_MV:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg - ADDR_W'(1);
                    ptr_next  = ptr_reg - ADDR_W'(1);
                end
            end
            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                ok_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_REM_MV:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (CNT_W'(ptr_reg) == cnt_last)
                begin
                    count_next = cnt_last;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + ADDR_W'(1);
                    ptr_next  = ptr_reg + ADDR_W'(1);
                end
            end
            S_FIND:
            begin
                if (ram_rdata == val_reg)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    found_next = FOUND_W'(ptr_reg);
                    state_next = S_IDLE;
                end
                else if (CNT_W'(ptr_reg) == cnt_last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + ADDR_W'(1);
                    ptr_next  = ptr_reg + ADDR_W'(1);
                end
            end
            S_READ:
            begin
                done_next  = 1'b1;
                ok_next    = 1'b1;
                rdv_next   = VALUE_W'(ram_rdata);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        len_next = LEN_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
        rdv_reg   <= rdv_next;
        len_reg   <= len_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign found_position = found_reg;
    assign read_value     = rdv_reg;
    assign length         = len_reg;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write hit the same entry in one cycle.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("List length exceeds capacity.");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_MV || state_reg == S_INS_PUT) |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("Insert sequence running on a full list.");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == OP_CLEAR) |=> (done && ok && length == '0))
        else $error("Clear did not report an empty list.");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_MV && ptr_reg != pos_reg) |=> !done)
        else $error("Result word issued while entries were still moving.");

endmodule
